// ----- hw/rtl/fag_pkg.sv -----
// Package: shared constants, types and controller state encoding.
`default_nettype none
package fag_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int PCW = $clog2(PW + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_N1, ST_MUL_N2, ST_MUL_D, ST_SUM,
        ST_EUC_START, ST_EUC_WAIT, ST_DIVN_START, ST_DIVN_WAIT,
        ST_DIVD_START, ST_DIVD_WAIT, ST_FINISH, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_N1, MUL_N2, MUL_D
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_EUC, DIV_QN, DIV_QD
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sum_en;
        logic     div_start;
        div_sel_t div_sel;
        logic     euc_step;
        logic     qn_take;
        logic     qd_take;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic y_zero;
        logic x_zero;
    } status_t;
endpackage
`default_nettype wire

// ----- hw/rtl/fag_divider.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module fag_divider
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [fag_pkg::PW-1:0] dividend,
    input  wire logic [fag_pkg::PW-1:0] divisor,
    output logic                      done,
    output logic [fag_pkg::PW-1:0]    quotient,
    output logic [fag_pkg::PW-1:0]    remainder
);
    logic [fag_pkg::PW-1:0]  q_reg, q_next;
    logic [fag_pkg::PW:0]    r_reg, r_next;
    logic [fag_pkg::PW-1:0]  d_reg, d_next;
    logic [fag_pkg::PCW-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [fag_pkg::PW:0]    trial;
    logic [fag_pkg::PW:0]    shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg[fag_pkg::PW-1:0], q_reg[fag_pkg::PW-1]};
        trial     = shifted - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = fag_pkg::PCW'(fag_pkg::PW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[fag_pkg::PW])
            begin
                r_next = trial;
                q_next = {q_reg[fag_pkg::PW-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[fag_pkg::PW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fag_pkg::PCW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[fag_pkg::PW-1:0];
endmodule
`default_nettype wire

// ----- hw/rtl/fag_datapath.sv -----
// Datapath: accumulator, products, Euclid registers, reduction and result.
`default_nettype none
module fag_datapath
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire fag_pkg::cmd_t cmd,
    output fag_pkg::status_t sts,
    input  wire logic [31:0] in_num,
    input  wire logic [31:0] in_den,
    input  wire logic        in_last,
    output logic [31:0]      res_num,
    output logic [31:0]      res_den,
    output logic             res_ovf,
    output logic             res_err,
    output logic             res_last
);
    localparam int VW = fag_pkg::VALUE_WIDTH;
    localparam int PW = fag_pkg::PW;

    logic [VW-1:0] acc_n_reg, acc_n_next;
    logic [VW-1:0] acc_d_reg, acc_d_next;
    logic          sa_reg, sb_reg, sc_reg, sd_reg;
    logic [VW-1:0] ma_reg, mb_reg, mc_reg, md_reg;
    logic [PW-1:0] m1_reg, m2_reg, mdn_reg, mn_reg, x_reg, y_reg, qn_reg;
    logic          s1_reg, s2_reg, sdn_reg, sn_reg, k_reg, last_reg;
    logic [31:0]   on_reg, od_reg;
    logic          ovf_reg, err_reg;

    logic [VW-1:0] vin_n, vin_d;
    logic [VW-1:0] mul_a, mul_b;
    logic [PW-1:0] prod;
    logic [PW:0]   sum_w;
    logic          sum_s;
    logic [PW-1:0] sum_m;
    logic          div_done;
    logic [PW-1:0] div_q, div_r, div_a, div_b;
    logic          sg, rs_n, rs_d, fit_n, fit_d;
    logic [PW-1:0] lim;
    logic [PW-1:0] rn, rd;

    function automatic logic [VW-1:0] mag(input logic [VW-1:0] v);
        mag = v[VW-1] ? (~v + 1'b1) : v;
    endfunction

    assign vin_n = in_num[VW-1:0];
    assign vin_d = in_den[VW-1:0];

    always_comb
    begin
        case (cmd.mul_sel)
            fag_pkg::MUL_N1: begin mul_a = ma_reg; mul_b = md_reg; end
            fag_pkg::MUL_N2: begin mul_a = mc_reg; mul_b = mb_reg; end
            default:         begin mul_a = mb_reg; mul_b = md_reg; end
        endcase
    end
    assign prod = {{VW{1'b0}}, mul_a} * {{VW{1'b0}}, mul_b};

    always_comb
    begin
        sum_w = '0;
        if (s1_reg == s2_reg)
        begin
            sum_s = s1_reg;
            sum_w = {1'b0, m1_reg} + {1'b0, m2_reg};
        end
        else if (m1_reg >= m2_reg)
        begin
            sum_s = s1_reg;
            sum_w = {1'b0, m1_reg - m2_reg};
        end
        else
        begin
            sum_s = s2_reg;
            sum_w = {1'b0, m2_reg - m1_reg};
        end
        sum_m = sum_w[PW-1:0];
    end

    always_comb
    begin
        case (cmd.div_sel)
            fag_pkg::DIV_EUC: begin div_a = x_reg;  div_b = y_reg; end
            fag_pkg::DIV_QN:  begin div_a = mn_reg; div_b = x_reg; end
            default:          begin div_a = mdn_reg; div_b = x_reg; end
        endcase
    end

    fag_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        sts.div_done = div_done;
        sts.y_zero   = (y_reg == '0);
        sts.x_zero   = (x_reg == '0);
    end

    assign sg   = k_reg ? sdn_reg : sn_reg;
    assign rs_n = (qn_reg != '0) && (sn_reg ^ sg);
    assign rs_d = (div_q != '0) && (sdn_reg ^ sg);
    assign lim  = PW'(1) << (VW - 1);
    assign fit_n = rs_n ? (qn_reg <= lim) : (qn_reg < lim);
    assign fit_d = rs_d ? (div_q <= lim) : (div_q < lim);
    assign rn   = rs_n ? (~qn_reg + 1'b1) : qn_reg;
    assign rd   = rs_d ? (~div_q + 1'b1) : div_q;

    always_comb
    begin
        acc_n_next = acc_n_reg;
        acc_d_next = acc_d_reg;
        if (cmd.qd_take)
        begin
            acc_n_next = rn[VW-1:0];
            acc_d_next = rd[VW-1:0];
        end
        if (cmd.finish && last_reg)
        begin
            acc_n_next = '0;
            acc_d_next = VW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_n_reg <= '0;
            acc_d_reg <= VW'(1);
        end
        else
        begin
            acc_n_reg <= acc_n_next;
            acc_d_reg <= acc_d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sa_reg   <= acc_n_reg[VW-1];
            ma_reg   <= mag(acc_n_reg);
            sb_reg   <= acc_d_reg[VW-1];
            mb_reg   <= mag(acc_d_reg);
            sc_reg   <= vin_n[VW-1];
            mc_reg   <= mag(vin_n);
            sd_reg   <= vin_d[VW-1];
            md_reg   <= mag(vin_d);
            last_reg <= in_last;
            ovf_reg  <= 1'b0;
            err_reg  <= 1'b0;
            k_reg    <= 1'b0;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                fag_pkg::MUL_N1:
                begin
                    m1_reg <= prod;
                    s1_reg <= (sa_reg ^ sd_reg) && (prod != '0);
                end
                fag_pkg::MUL_N2:
                begin
                    m2_reg <= prod;
                    s2_reg <= (sc_reg ^ sb_reg) && (prod != '0);
                end
                default:
                begin
                    mdn_reg <= prod;
                    sdn_reg <= (sb_reg ^ sd_reg) && (prod != '0);
                end
            endcase
        end
        if (cmd.sum_en)
        begin
            mn_reg <= sum_m;
            sn_reg <= sum_s && (sum_m != '0);
            x_reg  <= sum_m;
            y_reg  <= mdn_reg;
        end
        if (cmd.euc_step)
        begin
            x_reg <= y_reg;
            y_reg <= div_r;
            k_reg <= ~k_reg;
        end
        if (cmd.qn_take)
        begin
            qn_reg <= div_q;
        end
        if (cmd.qd_take)
        begin
            ovf_reg <= !fit_n || !fit_d;
        end
        if (cmd.finish)
        begin
            err_reg <= (x_reg == '0);
            on_reg  <= 32'(signed'(acc_n_reg));
            od_reg  <= 32'(signed'(acc_d_reg));
        end
    end

    assign res_num  = on_reg;
    assign res_den  = od_reg;
    assign res_ovf  = ovf_reg;
    assign res_err  = err_reg;
    assign res_last = last_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/fag_ctrl.sv -----
// Controller: sequences products, Euclid steps, reduction and output handshake.
`default_nettype none
module fag_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire fag_pkg::status_t sts,
    output fag_pkg::cmd_t        cmd
);
    fag_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fag_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = fag_pkg::MUL_N1;
        cmd.div_sel = fag_pkg::DIV_EUC;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            fag_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = fag_pkg::ST_MUL_N1;
                end
            end
            fag_pkg::ST_MUL_N1:
            begin
                cmd.mul_en = 1'b1;
                state_next = fag_pkg::ST_MUL_N2;
            end
            fag_pkg::ST_MUL_N2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fag_pkg::MUL_N2;
                state_next  = fag_pkg::ST_MUL_D;
            end
            fag_pkg::ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fag_pkg::MUL_D;
                state_next  = fag_pkg::ST_SUM;
            end
            fag_pkg::ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = fag_pkg::ST_EUC_START;
            end
            fag_pkg::ST_EUC_START:
            begin
                if (sts.y_zero)
                    state_next = sts.x_zero ? fag_pkg::ST_FINISH : fag_pkg::ST_DIVN_START;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = fag_pkg::ST_EUC_WAIT;
                end
            end
            fag_pkg::ST_EUC_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.euc_step = 1'b1;
                    state_next   = fag_pkg::ST_EUC_START;
                end
            end
            fag_pkg::ST_DIVN_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = fag_pkg::DIV_QN;
                state_next    = fag_pkg::ST_DIVN_WAIT;
            end
            fag_pkg::ST_DIVN_WAIT:
            begin
                cmd.div_sel = fag_pkg::DIV_QN;
                if (sts.div_done)
                begin
                    cmd.qn_take = 1'b1;
                    state_next  = fag_pkg::ST_DIVD_START;
                end
            end
            fag_pkg::ST_DIVD_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = fag_pkg::DIV_QD;
                state_next    = fag_pkg::ST_DIVD_WAIT;
            end
            fag_pkg::ST_DIVD_WAIT:
            begin
                cmd.div_sel = fag_pkg::DIV_QD;
                if (sts.div_done)
                begin
                    cmd.qd_take = 1'b1;
                    state_next  = fag_pkg::ST_FINISH;
                end
            end
            fag_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = fag_pkg::ST_OUT;
            end
            fag_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = fag_pkg::ST_IDLE;
            end
            default:
                state_next = fag_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/fraction_accumulator_gcd_core.sv -----
// Top level: running fraction sum reduced by a Euclid gcd.
//
//  channel | dir | tdata fields (low to high)          | tuser / tlast
//  s_axis  | in  | numerator[31:0], denominator[63:32] | tlast = final_item
//  m_axis  | out | sum_num[31:0], sum_den[63:32]       | tuser = overflow, zero_gcd_error;
//          |     |                                     | tlast = list_end
//
// One item at a time: the products and sum follow the transfer, then each Euclid
// remainder step runs in the shared 64-bit one-bit-per-cycle divider (up to about 90
// steps), then the two reduction divisions (skipped when the gcd is zero), then the
// finish state registers the result.
// Reset clears the sum to 0/1; the result register holds while m_axis_tready is low.
`default_nettype none
module fraction_accumulator_gcd_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // numerator, denominator
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // sum_num, sum_den
    output logic [1:0]       m_axis_tuser,  // overflow, zero_gcd_error
    output logic             m_axis_tlast
);
    fag_pkg::cmd_t    cmd;
    fag_pkg::status_t sts;
    logic [31:0]      res_num, res_den;
    logic             res_ovf, res_err, res_last;

    fag_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fag_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_num   (s_axis_tdata[31:0]),
        .in_den   (s_axis_tdata[63:32]),
        .in_last  (s_axis_tlast),
        .res_num  (res_num),
        .res_den  (res_den),
        .res_ovf  (res_ovf),
        .res_err  (res_err),
        .res_last (res_last)
    );

    assign m_axis_tdata = {res_den, res_num};
    assign m_axis_tuser = {res_err, res_ovf};
    assign m_axis_tlast = res_last;
endmodule
`default_nettype wire

// ----- tb/sv/fraction_accumulator_gcd_checker.sv -----
// Checker: predicts the reduced running fraction sum and compares each m_axis transfer.
`default_nettype none
module fraction_accumulator_gcd_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast,
    output int               fail_count,
    output int               pending_sums
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] sum_num;
        logic [31:0] sum_den;
        logic        overflow;
        logic        zero_gcd_error;
        logic        list_end;
    } sum_result_t;

    sum_result_t expected_sums[$];
    logic signed [31:0] run_num;
    logic signed [31:0] run_den;

    function automatic logic fits_width(logic neg, logic [63:0] mag);
        return neg ? (mag <= 64'h8000_0000) : (mag < 64'h8000_0000);
    endfunction

    task automatic add_fraction(logic [31:0] num_in, logic [31:0] den_in, logic last);
        logic na, nb, nc, nd, n1, n2, nn, ndn, ng, neg_n, neg_d;
        logic [63:0] ma, mb, mc, md, m1, m2, mn, mdn, x, y, r, g, qn, qd;
        int steps;
        sum_result_t res;
        na = run_num[31]; ma = na ? 64'(-run_num) : 64'(run_num);
        nb = run_den[31]; mb = nb ? 64'(-run_den) : 64'(run_den);
        nc = num_in[31];  mc = nc ? 64'(-$signed(num_in)) : 64'(num_in);
        nd = den_in[31];  md = nd ? 64'(-$signed(den_in)) : 64'(den_in);
        ma = ma & 64'hFFFF_FFFF; mb = mb & 64'hFFFF_FFFF;
        mc = mc & 64'hFFFF_FFFF; md = md & 64'hFFFF_FFFF;
        if (na && ma == 0) ma = 64'h8000_0000;
        if (nb && mb == 0) mb = 64'h8000_0000;
        if (nc && mc == 0) mc = 64'h8000_0000;
        if (nd && md == 0) md = 64'h8000_0000;
        n1 = na ^ nd; m1 = ma * md;
        n2 = nc ^ nb; m2 = mc * mb;
        if (m1 == 0) n1 = 1'b0;
        if (m2 == 0) n2 = 1'b0;
        if (n1 == n2)
        begin
            nn = n1; mn = m1 + m2;
        end
        else if (m1 >= m2)
        begin
            nn = n1; mn = m1 - m2;
        end
        else
        begin
            nn = n2; mn = m2 - m1;
        end
        if (mn == 0) nn = 1'b0;
        ndn = nb ^ nd; mdn = mb * md;
        if (mdn == 0) ndn = 1'b0;
        x = mn; y = mdn; steps = 0;
        while (y != 0)
        begin
            r = x % y; x = y; y = r; steps++;
        end
        g = x;
        ng = steps[0] ? ndn : nn;
        res = '0;
        if (g == 0)
            res.zero_gcd_error = 1'b1;
        else
        begin
            qn = mn / g; qd = mdn / g;
            neg_n = (qn != 0) && (nn ^ ng);
            neg_d = (qd != 0) && (ndn ^ ng);
            res.overflow = !fits_width(neg_n, qn) || !fits_width(neg_d, qd);
            run_num = neg_n ? 32'(-qn) : 32'(qn);
            run_den = neg_d ? 32'(-qd) : 32'(qd);
        end
        res.sum_num = run_num;
        res.sum_den = run_den;
        res.list_end = last;
        expected_sums.push_back(res);
        if (last)
        begin
            run_num = 0;
            run_den = 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sum_result_t want;
        if (!rst_n)
        begin
            run_num = 0;
            run_den = 1;
            fail_count = 0;
            expected_sums.delete();
            pending_sums = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    fail_count++;
                    $display("%t unexpected transfer: actual %h %b %b", $realtime,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (m_axis_tdata[31:0] !== want.sum_num)
                    begin
                        fail_count++;
                        $display("%t sum_num: expected %h actual %h", $realtime,
                                 want.sum_num, m_axis_tdata[31:0]);
                    end
                    if (m_axis_tdata[63:32] !== want.sum_den)
                    begin
                        fail_count++;
                        $display("%t sum_den: expected %h actual %h", $realtime,
                                 want.sum_den, m_axis_tdata[63:32]);
                    end
                    if (m_axis_tuser[0] !== want.overflow)
                    begin
                        fail_count++;
                        $display("%t overflow: expected %b actual %b", $realtime,
                                 want.overflow, m_axis_tuser[0]);
                    end
                    if (m_axis_tuser[1] !== want.zero_gcd_error)
                    begin
                        fail_count++;
                        $display("%t zero_gcd_error: expected %b actual %b", $realtime,
                                 want.zero_gcd_error, m_axis_tuser[1]);
                    end
                    if (m_axis_tlast !== want.list_end)
                    begin
                        fail_count++;
                        $display("%t list_end: expected %b actual %b", $realtime,
                                 want.list_end, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                add_fraction(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
            pending_sums = expected_sums.size();
        end
    end
endmodule
`default_nettype wire

// ----- tb/sv/fraction_accumulator_gcd_core_tb.sv -----
// Testbench top: drives fractions into the gcd accumulator and reports the verdict.
`default_nettype none
module fraction_accumulator_gcd_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending_sums;
    int          cycle_count = 0;
    int          sink_hold = 0;
    logic        calm = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    fraction_accumulator_gcd_core i_dut (.*);

    fraction_accumulator_gcd_checker i_checker (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fraction_accumulator_gcd_core_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 12);
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'(-$urandom_range(9)) : 32'($urandom_range(9));
            3: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_fraction(logic [31:0] num, logic [31:0] den, logic last);
        while (!calm && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {den, num};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_fraction(32'd1, 32'd2, 1'b0);
        send_fraction(32'd1, 32'd3, 1'b0);
        send_fraction(32'hFFFF_FFFF, 32'd6, 1'b1);
        send_fraction(32'd0, 32'd0, 1'b0);
        send_fraction(32'd0, 32'd5, 1'b1);
        send_fraction(32'd3, 32'hFFFF_FFFC, 1'b0);
        send_fraction(32'd1, 32'hFFFF_FFF9, 1'b1);
        send_fraction(32'h7FFF_FFFF, 32'd1, 1'b0);
        send_fraction(32'h7FFF_FFFF, 32'd1, 1'b1);
        send_fraction(32'h8000_0000, 32'd1, 1'b0);
        send_fraction(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_fraction(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_fraction(32'd1, 32'h7FFF_FFFF, 1'b0);
        send_fraction(32'd1, 32'h7FFF_FFFE, 1'b1);
        send_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_fraction(32'd5, 32'd0, 1'b1);
        send_fraction(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        send_fraction(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        sink_hold = 20000;
        for (int i = 0; i < 4; i++)
            send_fraction(pick_value(), pick_value(), i == 3);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_sums == 0);
        repeat (50) @(posedge clk);
        calm = 1'b1;
        for (int i = 0; i < 15; i++)
            send_fraction(pick_value(), pick_value(), $urandom_range(4) == 0);
        calm = 1'b0;
        for (int i = 0; i < 63; i++)
            send_fraction(pick_value(), pick_value(), $urandom_range(4) == 0);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_sums == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("fraction_accumulator_gcd_core_tb: PASS");
        else
            $display("fraction_accumulator_gcd_core_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
